@@ rtl/lzw_pkg.sv @@
// Shared types and constants of the LZW byte compressor.
`timescale 1ns / 1ps
`default_nettype none
package lzw_pkg;
    localparam int DICT_SIZE_DEF = 4096;
    localparam int CODE_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int FIRST_CODE    = 256;
    localparam int KEY_W         = CODE_W + BYTE_W;

    typedef struct packed {
        logic              eos;
        logic [BYTE_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic              last;
        logic [CODE_W-1:0] code;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT_MISS,
        ST_EMIT_EOS
    } t_state;

    // A raw byte maps to its single-byte code by inverting the top bit.
    function automatic logic [CODE_W-1:0] byte_code(input logic [BYTE_W-1:0] b);
        byte_code = CODE_W'({~b[BYTE_W-1], b[BYTE_W-2:0]});
    endfunction
endpackage
`default_nettype wire

@@ rtl/lzw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/lzw_fifo.sv @@
// Small first-word-fall-through queue used on the input and output sides.
`timescale 1ns / 1ps
`default_nettype none
module lzw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push_ok) - (PW+1)'(pop_ok);
        end
    end
endmodule
`default_nettype wire

@@ rtl/lzw_engine.sv @@
// Back end: dictionary search, insertion and code emission for one item at a time.
`timescale 1ns / 1ps
`default_nettype none
module lzw_engine import lzw_pkg::*; #(
    parameter int DICT_SIZE = DICT_SIZE_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_item_avail,
    input  t_item   i_item,
    output logic    o_item_pop,
    input  wire     i_res_full,
    output logic    o_res_push,
    output t_result o_res
);
    localparam int AW = $clog2(DICT_SIZE);
    localparam int NW = AW + 1;

    t_state              r_state, n_state;
    logic [CODE_W-1:0]   r_prefix, n_prefix;
    logic                r_pvalid, n_pvalid;
    logic [NW-1:0]       r_next, n_next;
    logic [NW-1:0]       r_k, n_k;
    logic                r_cv, n_cv;
    logic [NW-1:0]       r_ca, n_ca;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic                r_eos, n_eos;
    logic                we, issue, hit;
    logic [KEY_W-1:0]    rdata, key;
    logic [NW-1:0]       next_eff;

    lzw_ram #(.WIDTH(KEY_W), .DEPTH(DICT_SIZE)) u_dict (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_next[AW-1:0]),
        .i_wdata(key),
        .i_raddr(r_k[AW-1:0]),
        .o_rdata(rdata)
    );

    assign key      = {r_prefix, r_byte};
    assign issue    = (r_k < r_next);
    assign hit      = r_cv && (rdata == key);
    assign next_eff = (r_next >= NW'(DICT_SIZE)) ? NW'(FIRST_CODE) : r_next;

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_ca     <= n_ca;
        r_byte   <= n_byte;
        r_eos    <= n_eos;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pvalid <= 1'b0;
            r_next   <= NW'(FIRST_CODE);
            r_cv     <= 1'b0;
            r_prefix <= '0;
        end else begin
            r_state  <= n_state;
            r_pvalid <= n_pvalid;
            r_next   <= n_next;
            r_cv     <= n_cv;
            r_prefix <= n_prefix;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_prefix   = r_prefix;
        n_pvalid   = r_pvalid;
        n_next     = r_next;
        n_k        = r_k;
        n_cv       = 1'b0;
        n_ca       = r_k;
        n_byte     = r_byte;
        n_eos      = r_eos;
        we         = 1'b0;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        o_res.code = r_prefix;
        o_res.last = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_avail) begin
                    o_item_pop = 1'b1;
                    n_byte     = i_item.data;
                    n_eos      = i_item.eos;
                    n_next     = next_eff;
                    n_k        = NW'(FIRST_CODE);
                    if (!r_pvalid) begin
                        n_prefix = byte_code(i_item.data);
                        n_pvalid = 1'b1;
                        n_state  = i_item.eos ? ST_EMIT_EOS : ST_IDLE;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // One entry is read per cycle; the compare works on the registered read data of the RAM.
                if (hit) begin
                    n_prefix = CODE_W'(r_ca);
                    n_state  = r_eos ? ST_EMIT_EOS : ST_IDLE;
                end else if (!issue && !r_cv) begin
                    we      = 1'b1;
                    n_next  = r_next + NW'(1);
                    n_state = ST_EMIT_MISS;
                end else begin
                    n_cv = issue;
                    n_k  = r_k + NW'(issue);
                end
            end
            ST_EMIT_MISS: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_prefix   = byte_code(r_byte);
                    n_state    = r_eos ? ST_EMIT_EOS : ST_IDLE;
                end
            end
            ST_EMIT_EOS: begin
                o_res.last = 1'b1;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_prefix   = '0;
                    n_pvalid   = 1'b0;
                    n_next     = NW'(FIRST_CODE);
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= NW'(DICT_SIZE) && r_next >= NW'(FIRST_CODE))
        else $error("next free code out of range");
    a_no_prefix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pvalid |-> r_prefix == '0)
        else $error("prefix held without valid flag");
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEARCH |-> r_k <= r_next)
        else $error("search ran past the last entry");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");
endmodule
`default_nettype wire

@@ rtl/lzw_byte_compressor_core.sv @@
// Top level of the LZW byte compressor: input queue, search engine, output queue.
`timescale 1ns / 1ps
`default_nettype none
// Each input item is one byte (tdata) with tlast marking the final byte of a stream;
// each output item is one 16-bit LZW code with tlast on the stream's final code.
// Items are handled one at a time. The dictionary is searched linearly, one entry
// per cycle through the single read port of the dictionary RAM, so an item's search
// reads up to N entries, where N is the number of entries added since the dictionary
// was last restarted (0 to DICT_SIZE-256); the first byte of a stream needs no search,
// and each emitted code passes through an emit state. Two-entry queues on both sides let the
// input keep filling while results wait to be taken. No clearing pass after reset.
module lzw_byte_compressor_core import lzw_pkg::*; #(
    parameter int DICT_SIZE = DICT_SIZE_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire  [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  wire          i_s_axis_tlast,   // end_of_stream
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    output logic [15:0]  o_m_axis_tdata,   // [15:0] code
    output logic         o_m_axis_tlast    // last_code
);
    t_item   in_item, q_item;
    t_result res, q_res;
    logic    in_full, in_empty, item_pop;
    logic    res_full, res_empty, res_push;

    assign in_item.data    = i_s_axis_tdata;
    assign in_item.eos     = i_s_axis_tlast;
    assign o_s_axis_tready = !in_full;

    lzw_fifo #(.WIDTH($bits(t_item)), .DEPTH(2)) u_in_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_s_axis_tvalid),
        .i_data (in_item),
        .o_full (in_full),
        .i_pop  (item_pop),
        .o_data (q_item),
        .o_empty(in_empty)
    );

    lzw_engine #(.DICT_SIZE(DICT_SIZE)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_avail(!in_empty),
        .i_item      (q_item),
        .o_item_pop  (item_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    lzw_fifo #(.WIDTH($bits(t_result)), .DEPTH(2)) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res),
        .o_full (res_full),
        .i_pop  (i_m_axis_tready),
        .o_data (q_res),
        .o_empty(res_empty)
    );

    assign o_m_axis_tvalid = !res_empty;
    assign o_m_axis_tdata  = q_res.code;
    assign o_m_axis_tlast  = q_res.last;
endmodule
`default_nettype wire
